>>> rtl/core/assert_macros.svh
// Assertion macros used by the outlier-gated moving average back end.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define OGMA_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication that must hold in the same cycle.
`define OGMA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define OGMA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ogma_pkg.sv
// ----------------------------------------------------------------------------
// ogma_pkg
// Types and constants shared by the outlier-gated moving average modules.
// ----------------------------------------------------------------------------
package ogma_pkg;

  localparam int HIST_DEPTH = 1024;
  localparam int PTR_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 16;
  localparam int PRIME_W    = 11;
  localparam int MEAN_W     = 20;
  localparam int MEAN_FRAC_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // The sum of a full history of valid samples.
  localparam int SUM_W      = SAMPLE_W + PTR_W + 1;
  localparam int DIVIDEND_W = SUM_W + MEAN_FRAC_W;
  // Two quotient bits are produced per iteration.
  localparam int DIV_ITER   = (DIVIDEND_W + 1) / 2;
  localparam int QUO_W      = 2 * DIV_ITER;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);

  localparam int XC_W       = SAMPLE_W + CNT_W;
  localparam int TS_W       = THR_W + SUM_W;
  localparam int DEV_SHIFT  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_COUNT      = 2'd2;

  localparam logic [THR_W-1:0]    RESET_THRESHOLD   = 16'd655;
  localparam logic [SAMPLE_W-1:0] RESET_UPPER_LIMIT = 16'd2500;
  localparam logic [PRIME_W-1:0]  RESET_PRIME_COUNT = 11'd599;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sample_missing;
  } sample_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_value;
    logic              mean_valid;
    logic              accepted;
  } result_item_t;

  // An item as classified by the front: over_limit marks a sample that is
  // missing or at or above the upper limit.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sample_missing;
    logic                over_limit;
  } queue_item_t;

  typedef struct packed {
    logic [THR_W-1:0]    accept_threshold;
    logic [SAMPLE_W-1:0] upper_limit;
    logic [PRIME_W-1:0]  prime_count;
  } cfg_t;

endpackage

>>> rtl/core/ogma_front.sv
// ----------------------------------------------------------------------------
// ogma_front
// Accepts sample beats, classifies them against the upper limit and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ogma_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  ogma_pkg::sample_item_t sample_item,
  input  ogma_pkg::cfg_t        cfg,
  output logic                  head_valid,
  output ogma_pkg::queue_item_t head_item,
  input  logic                  head_pop
);
  import ogma_pkg::*;

  queue_item_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;
  queue_item_t classified;

  assign sample_stall = (fill == 2'd2);
  assign push         = sample_valid && !sample_stall;
  assign pop          = head_pop && head_valid;
  assign head_valid   = (fill != 2'd0);
  assign head_item    = entries[rd_ptr];

  always_comb begin
    classified.sample         = sample_item.sample;
    classified.sample_missing = sample_item.sample_missing;
    classified.over_limit     = sample_item.sample_missing ||
                                (sample_item.sample >= cfg.upper_limit);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/ogma_div.sv
// ----------------------------------------------------------------------------
// ogma_div
// Iterative restoring divider producing two quotient bits per cycle, used
// to form the mean from the running sum and count.
// ----------------------------------------------------------------------------
module ogma_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ogma_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [ogma_pkg::CNT_W-1:0]    divisor,
  output logic                          busy,
  output logic [ogma_pkg::QUO_W-1:0]    quotient
);
  import ogma_pkg::*;

  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dvsr;
  logic [QUO_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] iter;
  logic [CNT_W-1:0]     rem_mid;
  logic [CNT_W-1:0]     rem_next;
  logic                 q_hi;
  logic                 q_lo;

  // One restoring step: shift a dividend bit into the remainder and take
  // the divisor off when it fits. Returns {quotient bit, new remainder}.
  function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] r,
                                              input logic             b,
                                              input logic [CNT_W-1:0] d);
    logic [CNT_W:0] trial;
    logic [CNT_W:0] diff;
    trial = {r, b};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {1'b1, diff[CNT_W-1:0]};
    end else begin
      div_step = {1'b0, trial[CNT_W-1:0]};
    end
  endfunction

  always_comb begin
    {q_hi, rem_mid}  = div_step(rem, quo[QUO_W-1], dvsr);
    {q_lo, rem_next} = div_step(rem_mid, quo[QUO_W-2], dvsr);
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvsr <= divisor;
      quo  <= QUO_W'(dividend);
    end else if (busy) begin
      rem  <= rem_next;
      quo  <= {quo[QUO_W-3:0], q_hi, q_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= DIV_CNT_W'(DIV_ITER - 1);
    end else if (busy) begin
      if (iter == '0) begin
        busy <= 1'b0;
      end else begin
        iter <= iter - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ogma_back.sv
// ----------------------------------------------------------------------------
// ogma_back
// Processes one queued sample at a time: retires a full history's oldest entry,
// divides for the mean, applies the deviation test and stores the decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ogma_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ogma_pkg::cfg_t         cfg,
  input  logic                   head_valid,
  input  ogma_pkg::queue_item_t  head_item,
  output logic                   head_pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output ogma_pkg::result_item_t result_item
);
  import ogma_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DROP   = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  state_t               state;
  state_t               state_next;
  queue_item_t          item;

  logic [SAMPLE_W:0]    mem [HIST_DEPTH];
  logic [SAMPLE_W:0]    rdata;

  logic [PTR_W-1:0]     write_pointer;
  logic [CNT_W-1:0]     fill_level;
  logic [SUM_W-1:0]     valid_sum;
  logic [CNT_W-1:0]     valid_count;
  logic [PRIME_W-1:0]   primed_seen;

  logic [XC_W-1:0]      xc;
  logic [TS_W-1:0]      ts;
  logic                 dev_ok;
  logic [XC_W-1:0]      dev;
  logic [XC_W-1:0]      sum_ext;

  logic                 div_start;
  logic                 div_busy;
  logic [QUO_W-1:0]     quotient;

  logic                 out_free;
  logic                 commit;
  logic                 have_mean;
  logic                 priming;
  logic                 acc;

  ogma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({valid_sum, {MEAN_FRAC_W{1'b0}}}),
    .divisor  (valid_count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign out_free  = !result_valid || !result_stall;
  assign head_pop  = (state == ST_IDLE) && head_valid;
  assign div_start = (state == ST_MUL);
  assign commit    = (state == ST_COMMIT) && out_free;
  assign have_mean = (valid_count != '0);
  assign priming   = (primed_seen < cfg.prime_count);

  assign sum_ext = XC_W'(valid_sum);
  assign dev     = (sum_ext > xc) ? (sum_ext - xc) : (xc - sum_ext);

  always_comb begin
    if (priming) begin
      acc = !item.sample_missing;
    end else if (item.over_limit) begin
      acc = 1'b0;
    end else if (!have_mean) begin
      acc = 1'b1;
    end else begin
      acc = dev_ok;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          state_next = ST_DROP;
        end
      end
      ST_DROP:   state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // The oldest entry sits at the write pointer, so it is read every cycle.
  always_ff @(posedge clk) begin
    rdata <= mem[write_pointer];
    if (commit) begin
      mem[write_pointer] <= acc ? {1'b1, item.sample} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      item <= head_item;
    end
    if (state == ST_MUL) begin
      xc <= item.sample * valid_count;
      ts <= cfg.accept_threshold * valid_sum;
    end
    if (state == ST_DIV) begin
      dev_ok <= {dev, {DEV_SHIFT{1'b0}}} < (XC_W + DEV_SHIFT)'(ts);
    end
    if (commit) begin
      result_item.mean_value <= have_mean ? quotient[MEAN_W-1:0] : '0;
      result_item.mean_valid <= have_mean;
      result_item.accepted   <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_valid  <= 1'b0;
      write_pointer <= '0;
      fill_level    <= '0;
      valid_sum     <= '0;
      valid_count   <= '0;
      primed_seen   <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if ((state == ST_DROP) && (fill_level == CNT_W'(HIST_DEPTH))) begin
        fill_level <= fill_level - 1'b1;
        if (rdata[SAMPLE_W]) begin
          valid_sum   <= valid_sum - SUM_W'(rdata[SAMPLE_W-1:0]);
          valid_count <= valid_count - 1'b1;
        end
      end
      if (commit) begin
        fill_level    <= fill_level + 1'b1;
        write_pointer <= (write_pointer == PTR_W'(HIST_DEPTH - 1)) ? '0
                         : write_pointer + 1'b1;
        if (priming) begin
          primed_seen <= primed_seen + 1'b1;
        end
        if (acc) begin
          valid_sum   <= valid_sum + SUM_W'(item.sample);
          valid_count <= valid_count + 1'b1;
        end
      end
    end
  end

  `OGMA_ASSERT(a_count_within_fill, valid_count <= fill_level, "valid count exceeds fill level")
  `OGMA_ASSERT(a_fill_bounded, fill_level <= CNT_W'(HIST_DEPTH), "history fill level overflow")
  `OGMA_ASSERT_IMP(a_commit_after_div, commit, !div_busy, "result committed while divider busy")
  `OGMA_ASSERT_NEXT(a_pop_starts_item, head_pop, state == ST_DROP, "popped item not taken up")

endmodule

>>> rtl/core/outlier_gated_moving_average_top.sv
// A sample beat passes through the back-end states idle, drop, multiply, divide and
// commit; divide holds while the divider runs its two-bit iterations, commit while
// the previous result waits on result_stall, and the next sample is taken up only
// after commit. Two further samples are queued while one is processed.
// Reset (rst, synchronous) empties the history and the queue and loads the
// default configuration; history storage itself is not cleared.
// ----------------------------------------------------------------------------
// outlier_gated_moving_average_top
// Moving average of sensor samples with gating of outliers, holding the
// configuration registers and joining the front queue to the back end.
// ----------------------------------------------------------------------------
module outlier_gated_moving_average_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  ogma_pkg::sample_item_t              sample_item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output ogma_pkg::result_item_t              result_item,
  input  logic                                cfg_write,
  input  logic [ogma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ogma_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ogma_pkg::*;

  cfg_t        cfg;
  logic        head_valid;
  queue_item_t head_item;
  logic        head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accept_threshold <= RESET_THRESHOLD;
      cfg.upper_limit      <= RESET_UPPER_LIMIT;
      cfg.prime_count      <= RESET_PRIME_COUNT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ACCEPT_THRESHOLD: cfg.accept_threshold <= cfg_data[THR_W-1:0];
        CFG_UPPER_LIMIT:      cfg.upper_limit      <= cfg_data[SAMPLE_W-1:0];
        CFG_PRIME_COUNT:      cfg.prime_count      <= cfg_data[PRIME_W-1:0];
        default: ;
      endcase
    end
  end

  ogma_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .head_pop     (head_pop)
  );

  ogma_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .head_pop     (head_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

>>> sim/tb_outlier_gated_moving_average_top.sv
// ----------------------------------------------------------------------------
// tb_outlier_gated_moving_average_top
// Self-checking bench for the outlier-gated moving average. A behavioural
// copy of the history, running sum and sample gating predicts every result
// beat, and each beat is compared field by field as it leaves the block.
// Directed beats cover the limits and the special cases. Random phases then
// move the registers between settings, with sender gaps, receiver stalls or both.
// ----------------------------------------------------------------------------
module tb_outlier_gated_moving_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ogma_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 60;
  localparam int MAX_REPORTS    = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_item_t          sample_item  = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_item_t          result_item;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Predicted state of the block.
  bit [SAMPLE_W:0]   hist_mem [HIST_DEPTH];
  bit [PTR_W-1:0]    hist_wr       = '0;
  int                hist_fill     = 0;
  bit [SUM_W-1:0]    run_sum       = '0;
  bit [CNT_W-1:0]    run_count     = '0;
  bit [PRIME_W-1:0]  primed_so_far = '0;
  bit [THR_W-1:0]    thr_reg       = RESET_THRESHOLD;
  bit [SAMPLE_W-1:0] limit_reg     = RESET_UPPER_LIMIT;
  bit [PRIME_W-1:0]  prime_reg     = RESET_PRIME_COUNT;

  result_item_t means_due [$];

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_asked   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;
  int results_seen = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  outlier_gated_moving_average_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  function automatic result_item_t predict_average(input sample_item_t it);
    result_item_t    r;
    bit [SAMPLE_W:0] oldest;
    bit [47:0]       scaled_sum;
    bit [47:0]       xc;
    bit [47:0]       dev;
    bit [47:0]       lhs;
    bit [47:0]       rhs;
    bit              have_mean;
    bit              take;
    // The oldest entry sits under the write pointer once the history is full.
    if (hist_fill == HIST_DEPTH) begin
      oldest = hist_mem[hist_wr];
      if (oldest[SAMPLE_W]) begin
        run_sum   = run_sum - oldest[SAMPLE_W-1:0];
        run_count = run_count - 1'b1;
      end
      hist_fill--;
    end
    have_mean  = (run_count != 0);
    scaled_sum = run_sum;
    scaled_sum = scaled_sum << MEAN_FRAC_W;
    if (have_mean) begin
      scaled_sum = scaled_sum / run_count;
    end else begin
      scaled_sum = '0;
    end
    if (primed_so_far < prime_reg) begin
      take = !it.sample_missing;
      primed_so_far++;
    end else if (it.sample_missing || it.sample >= limit_reg) begin
      take = 1'b0;
    end else if (!have_mean) begin
      take = 1'b1;
    end else begin
      xc  = it.sample;
      xc  = xc * run_count;
      dev = (run_sum > xc) ? run_sum - xc : xc - run_sum;
      lhs = dev << DEV_SHIFT;
      rhs = thr_reg;
      rhs = rhs * run_sum;
      take = (lhs < rhs);
    end
    hist_mem[hist_wr] = take ? {1'b1, it.sample} : '0;
    if (take) begin
      run_sum   = run_sum + it.sample;
      run_count = run_count + 1'b1;
    end
    hist_wr = hist_wr + 1'b1;
    hist_fill++;
    r.mean_value = scaled_sum[MEAN_W-1:0];
    r.mean_valid = have_mean;
    r.accepted   = take;
    return r;
  endfunction

  function automatic int mean_now(input int fallback);
    if (run_count == 0) return fallback;
    return int'(run_sum / run_count);
  endfunction

  function automatic sample_item_t make_beat(input int value, input bit missing);
    sample_item_t it;
    it.sample         = value[SAMPLE_W-1:0];
    it.sample_missing = missing;
    return it;
  endfunction

  // Mostly samples near the given centre; missing beats and full-range noise
  // make up the rest.
  function automatic sample_item_t draw_sample(input int centre, input int spread,
                                               input int noise_pct);
    sample_item_t it;
    int           pick;
    int           v;
    pick = int'($urandom_range(0, 99));
    it.sample_missing = (pick < 5);
    if (pick < 5 + noise_pct) begin
      v = int'($urandom_range(0, 65535));
    end else begin
      v = centre - spread + int'($urandom_range(0, 2 * spread));
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end
    it.sample = v[SAMPLE_W-1:0];
    return it;
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_ACCEPT_THRESHOLD: thr_reg = val;
      CFG_UPPER_LIMIT:      limit_reg = val;
      CFG_PRIME_COUNT:      prime_reg = val[PRIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input sample_item_t it);
    cfg_write <= 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= it;
    do @(posedge clk); while (sample_stall);
    means_due.push_back(predict_average(it));
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    cfg_write    <= 1'b0;
    do @(posedge clk); while (means_due.size() != 0);
  endtask

  task automatic run_samples(input int count, input int centre, input int spread,
                             input int noise_pct);
    int base;
    for (int i = 0; i < count; i++) begin
      base = (centre < 0) ? mean_now(1800) : centre;
      send_sample(draw_sample(base, spread, noise_pct));
    end
  endtask

  task automatic test_reset_defaults();
    // A missing beat still uses up one of the reset priming slots.
    send_sample(make_beat(65535, 1'b1));
    drain_results();
    write_reg(CFG_PRIME_COUNT, 16'd0);
    // Priming ends at once; with no mean yet only presence and the limit decide.
    send_sample(make_beat(2500, 1'b0));
    send_sample(make_beat(65535, 1'b0));
    send_sample(make_beat(100, 1'b1));
    send_sample(make_beat(0, 1'b0));
    // Valid entries that are all zero give a zero mean, which rejects anything.
    send_sample(make_beat(0, 1'b0));
    send_sample(make_beat(2499, 1'b0));
    drain_results();
  endtask

  task automatic test_priming_restart();
    // Bits above the prime count field are dropped, leaving five.
    write_reg(CFG_PRIME_COUNT, 16'hF805);
    send_sample(make_beat(65535, 1'b0));
    send_sample(make_beat(1, 1'b0));
    send_sample(make_beat(0, 1'b1));
    send_sample(make_beat(2000, 1'b0));
    send_sample(make_beat(2000, 1'b0));
    drain_results();
  endtask

  task automatic test_register_extremes();
    int centre;
    write_reg(CFG_ACCEPT_THRESHOLD, 16'hFFFF);
    write_reg(CFG_UPPER_LIMIT, 16'hFFFF);
    send_sample(make_beat(65535, 1'b0));
    send_sample(make_beat(20000, 1'b0));
    send_sample(make_beat(0, 1'b0));
    drain_results();
    write_reg(CFG_ACCEPT_THRESHOLD, 16'd0);
    send_sample(make_beat(mean_now(0), 1'b0));
    drain_results();
    write_reg(CFG_UPPER_LIMIT, 16'd0);
    send_sample(make_beat(0, 1'b0));
    drain_results();
    // The spare index has no register behind it.
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(CFG_ACCEPT_THRESHOLD, 16'd1000);
    write_reg(CFG_UPPER_LIMIT, 16'd30000);
    centre = mean_now(1000);
    send_sample(make_beat(centre, 1'b0));
    send_sample(make_beat(centre + centre / 50, 1'b0));
    send_sample(make_beat(centre - centre / 200, 1'b0));
    drain_results();
  endtask

  task automatic test_priming_window();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(CFG_ACCEPT_THRESHOLD, 16'd655);
    write_reg(CFG_UPPER_LIMIT, 16'd2500);
    write_reg(CFG_PRIME_COUNT, 16'd1024);
    run_samples(200, 1800, 40, 0);
    drain_results();
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 62;
    stall_pct = 0;
    // Lowering the prime count below the beats already seen ends priming.
    write_reg(CFG_PRIME_COUNT, 16'd40);
    run_samples(400, -1, 40, 6);
    drain_results();
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 62;
    write_reg(CFG_ACCEPT_THRESHOLD, 16'd6553);
    write_reg(CFG_UPPER_LIMIT, 16'hFFFF);
    run_samples(400, -1, 300, 8);
    drain_results();
  endtask

  task automatic test_both_idle();
    idle_pct  = 36;
    stall_pct = 36;
    write_reg(CFG_ACCEPT_THRESHOLD, 16'hFFFF);
    write_reg(CFG_UPPER_LIMIT, 16'd40000);
    run_samples(400, -1, 2500, 10);
    drain_results();
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(CFG_ACCEPT_THRESHOLD, 16'd300);
    write_reg(CFG_UPPER_LIMIT, 16'd20000);
    for (int burst = 0; burst < 4; burst++) begin
      // The receiver holds off while beats keep coming, so the queue fills up.
      hold_asked++;
      run_samples(100, -1, 40, 5);
    end
    drain_results();
  endtask

  // Result side: random stalls, with a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen    <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    result_item_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (means_due.size() == 0) begin
        log_mismatch($sformatf("result beat %0d with no sample outstanding: mean %0d valid %0b accepted %0b",
                               results_seen, result_item.mean_value,
                               result_item.mean_valid, result_item.accepted));
      end else begin
        want = means_due.pop_front();
        if (result_item.mean_value !== want.mean_value ||
            result_item.mean_valid !== want.mean_valid ||
            result_item.accepted !== want.accepted) begin
          log_mismatch($sformatf({"result beat %0d: expected mean %0d valid %0b accepted %0b,",
                                  " got mean %0d valid %0b accepted %0b"},
                                 results_seen, want.mean_value, want.mean_valid,
                                 want.accepted, result_item.mean_value,
                                 result_item.mean_valid, result_item.accepted));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_priming_restart();
    test_register_extremes();
    test_priming_window();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && means_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
